### hw/rtl/sorted_interval_broad_phase_unit_defines.svh
// Assertion macros used by the broad phase top level.
`ifndef SORTED_INTERVAL_BROAD_PHASE_UNIT_DEFINES_SVH
`define SORTED_INTERVAL_BROAD_PHASE_UNIT_DEFINES_SVH

// Same-cycle implication, ignored while reset is held.
`define SIBP_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is held.
`define SIBP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/sibp_pkg.sv
// Types and codes shared by the broad phase cells and top level.
package sibp_pkg;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_UPDATE = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_QUERY  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_DUP       = 2'd3;

  typedef struct packed {
    logic        [31:0] id;
    logic signed [31:0] pos;
    logic        [30:0] rad;
  } entry_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_WRITE,
    CELL_REMOVE,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
  } cell_ctrl_t;

endpackage

### hw/rtl/sorted_interval_broad_phase_unit.sv
// Top level of the one-dimensional sorted interval broad phase.
//
// Commands arrive on the in_ stream: tuser carries the command code and
// tdata the body id, two positions and the radius. Each command produces
// one or more transfers on the out_ stream; tlast marks the final one.
// The table is held in a chain of cells kept in ascending id order, so a
// query that walks the chain from its head yields ids already in order.
// Insert shifts the larger ids one cell along in the decide step and
// then finishes. Update and remove change the chain in the decide step
// and then rotate the whole chain once through its head to find the new
// largest radius. A query rotates the chain the same way, testing the
// head cell against the widened range at each rotation step.
// One command is worked on at a time; in_tready is high only when idle.
// A hit is held in a pending register until the next hit or the finish,
// so that tlast can be set on the final one.
// When the receiver stalls, the rotation pauses on the next hit until the
// output register frees, so no transfer is lost. Reset empties the table
// and clears the search radius; cell contents are not cleared.
module sorted_interval_broad_phase_unit
  import sibp_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [1:0]   in_tuser,   // cmd[1:0]
  input  logic [127:0] in_tdata,   // body_id[31:0], pos_a[63:32], pos_b[95:64],
                                   // radius[126:96], zero[127]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [2:0]   out_tuser,  // status[1:0], hit_valid[2]
  output logic [31:0]  out_tdata,  // hit_id[31:0]
  output logic         out_tlast
);

`include "sorted_interval_broad_phase_unit_defines.svh"

  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {S_IDLE, S_DECIDE, S_ROTATE, S_FINISH} state_t;

  state_t             state_r;
  logic [1:0]         cmd_r;
  entry_t             new_r;
  logic signed [31:0] pos_b_r;
  logic signed [33:0] lo_r, hi_r;
  logic [SW-1:0]      step_r;
  logic [30:0]        acc_r;
  logic [CW-1:0]      count_r;
  logic [30:0]        sr_r;
  logic               pend_valid_r;
  logic [31:0]        pend_id_r;
  logic [1:0]         fin_status_r;
  logic               out_valid_r;
  logic [2:0]         out_user_r;
  logic [31:0]        out_data_r;
  logic               out_last_r;

  entry_t               cell_e [CAPACITY];
  logic [CAPACITY-1:0]  cell_gt, cell_match, occ;
  cell_ctrl_t           ctrl;

  logic any_match, can_push, head_occ, head_hit, adv, rot_end;
  logic push_hit, push_fin;
  logic signed [33:0] head_pos;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_user_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  assign any_match = |cell_match;
  assign can_push  = !out_valid_r || out_tready;
  assign head_occ  = {{(CW-SW){1'b0}}, step_r} < count_r;
  assign head_pos  = {{2{cell_e[0].pos[31]}}, cell_e[0].pos};
  assign head_hit  = head_occ && (cmd_r == CMD_QUERY) && head_pos >= lo_r && head_pos <= hi_r;
  assign adv       = !(head_hit && pend_valid_r && !can_push);
  assign rot_end   = step_r == SW'(CAPACITY - 1);
  assign push_hit  = (state_r == S_ROTATE) && adv && head_hit && pend_valid_r;
  assign push_fin  = (state_r == S_FINISH) && can_push;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      entry_t left_e;
      logic   left_occ;
      logic   left_gt;
      assign occ[gi] = CW'(gi) < count_r;
      if (gi == 0) begin : g_head
        assign left_e   = new_r;
        assign left_occ = 1'b1;
        assign left_gt  = 1'b0;
      end else begin : g_body
        assign left_e   = cell_e[gi-1];
        assign left_occ = occ[gi-1];
        assign left_gt  = cell_gt[gi-1];
      end
      sibp_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .occ      (occ[gi]),
        .new_e    (new_r),
        .left_e   (left_e),
        .left_occ (left_occ),
        .left_gt  (left_gt),
        .right_e  (cell_e[(gi + 1) % CAPACITY]),
        .e        (cell_e[gi]),
        .gt       (cell_gt[gi]),
        .match    (cell_match[gi])
      );
    end
  endgenerate

  // The insert slot is the first cell holding a larger id, or the first free
  // cell when no held id is larger.
  logic ins_ok;
  assign ins_ok = !any_match && (count_r < CW'(CAPACITY));

  always_comb begin
    ctrl.op = CELL_HOLD;
    unique case (state_r)
      S_DECIDE: begin
        unique case (cmd_r)
          CMD_INSERT: if (ins_ok)    ctrl.op = CELL_INSERT;
          CMD_UPDATE: if (any_match) ctrl.op = CELL_WRITE;
          CMD_REMOVE: if (any_match) ctrl.op = CELL_REMOVE;
          default:    ctrl.op = CELL_HOLD;
        endcase
      end
      S_ROTATE: if (adv) ctrl.op = CELL_ROTATE;
      default:  ctrl.op = CELL_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      sr_r         <= '0;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      if (push_hit || push_fin) out_valid_r <= 1'b1;
      else if (out_tready)      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            cmd_r      <= in_tuser;
            new_r.id   <= in_tdata[31:0];
            new_r.pos  <= in_tdata[63:32];
            pos_b_r    <= in_tdata[95:64];
            new_r.rad  <= in_tdata[126:96];
            state_r    <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          step_r       <= '0;
          acc_r        <= '0;
          pend_valid_r <= 1'b0;
          if (new_r.pos > pos_b_r) begin
            lo_r <= {{2{pos_b_r[31]}}, pos_b_r} - $signed({3'b000, sr_r});
            hi_r <= {{2{new_r.pos[31]}}, new_r.pos} + $signed({3'b000, sr_r});
          end else begin
            lo_r <= {{2{new_r.pos[31]}}, new_r.pos} - $signed({3'b000, sr_r});
            hi_r <= {{2{pos_b_r[31]}}, pos_b_r} + $signed({3'b000, sr_r});
          end
          unique case (cmd_r)
            CMD_INSERT: begin
              state_r <= S_FINISH;
              if (any_match) fin_status_r <= ST_DUP;
              else if (!ins_ok) fin_status_r <= ST_FULL;
              else begin
                fin_status_r <= ST_OK;
                count_r <= count_r + CW'(1);
                if (new_r.rad > sr_r) sr_r <= new_r.rad;
              end
            end
            CMD_QUERY: begin
              fin_status_r <= ST_OK;
              state_r      <= S_ROTATE;
            end
            default: begin
              if (!any_match) begin
                fin_status_r <= ST_NOT_FOUND;
                state_r      <= S_FINISH;
              end else begin
                fin_status_r <= ST_OK;
                if (cmd_r == CMD_REMOVE) count_r <= count_r - CW'(1);
                state_r <= S_ROTATE;
              end
            end
          endcase
        end
        S_ROTATE: begin
          if (adv) begin
            step_r <= step_r + SW'(1);
            if (head_occ && cell_e[0].rad > acc_r) acc_r <= cell_e[0].rad;
            if (head_hit) begin
              if (pend_valid_r) begin
                out_user_r  <= {1'b1, ST_OK};
                out_data_r  <= pend_id_r;
                out_last_r  <= 1'b0;
              end
              pend_valid_r <= 1'b1;
              pend_id_r    <= cell_e[0].id;
            end
            if (rot_end) begin
              state_r <= S_FINISH;
              if (cmd_r != CMD_QUERY) begin
                sr_r <= (head_occ && cell_e[0].rad > acc_r) ? cell_e[0].rad : acc_r;
              end
            end
          end
        end
        S_FINISH: begin
          if (can_push) begin
            out_user_r  <= {pend_valid_r, fin_status_r};
            out_data_r  <= pend_valid_r ? pend_id_r : 32'd0;
            out_last_r  <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `SIBP_ASSERT(a_count_cap, 1'b1, count_r <= CW'(CAPACITY), "entry count exceeds capacity")
  `SIBP_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, state_r == S_DECIDE,
    "accepted command did not start")
  `SIBP_ASSERT_NEXT(a_rotate_hold, state_r == S_ROTATE && !adv, $stable(step_r),
    "rotation moved while stalled")

endmodule

### hw/rtl/sibp_cell.sv
// One table slot of the id-ordered chain, with its neighbour moves.
module sibp_cell
  import sibp_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       occ,
  input  entry_t     new_e,
  input  entry_t     left_e,
  input  logic       left_occ,
  input  logic       left_gt,
  input  entry_t     right_e,
  output entry_t     e,
  output logic       gt,
  output logic       match
);

  entry_t e_r;
  logic   ge;

  assign e     = e_r;
  assign gt    = occ && (e_r.id > new_e.id);
  assign ge    = e_r.id >= new_e.id;
  assign match = occ && (e_r.id == new_e.id);

  always_ff @(posedge clk) begin
    case (ctrl.op)
      CELL_INSERT: begin
        // A cell holding a larger id, and the first free cell, take either the
        // entry shifted in from the left or the new body.
        if (gt || (!occ && left_occ)) begin
          e_r <= left_gt ? left_e : new_e;
        end
      end
      CELL_WRITE: begin
        if (match) begin
          e_r.pos <= new_e.pos;
          e_r.rad <= new_e.rad;
        end
      end
      CELL_REMOVE: begin
        if (ge) e_r <= right_e;
      end
      CELL_ROTATE: e_r <= right_e;
      default: e_r <= e_r;
    endcase
  end

endmodule
